@@ design/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

	// Field widths of the stream items.
	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int NIB_W  = 4;
	localparam int IDX_W  = 11;
	localparam int LOC_W  = 11;
	localparam int CELL_W = 16;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int TDATA_W = 32;

	// Blank cell: space, white on black.
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LAST      = 8'h7F;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FILL,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ design/tcw_ram.sv @@
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/text_console_writer.sv @@
// Text console writer: a screen of COLUMNS x ROWS cells of 16 bits each
// (attribute in the high byte, character in the low byte) with a cursor.
// Input items arrive on the s_ group: an operation (put character, clear
// screen, read one cell), the character, the two color nibbles and a cell
// index. Every item gives exactly one result item on the m_ group: the linear
// cursor location after the operation and, for a read, the cell contents.
// One item is worked on at a time. A put without scroll, a read past the end
// of the screen and an unused code go from idle straight to the done state;
// a read of a cell on the screen passes through a read state first, for the
// registered read port of the screen memory. A put that scrolls copies every
// row up one cell per cycle through the single memory port pair and then
// blanks the bottom row; a clear writes every cell.
// After reset a clearing pass blanks the memory; no item is accepted during
// it. A finished result waits in an output register, so a stalled receiver
// holds it there while the next item is already accepted and worked on; that
// item's result waits until the register frees.
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	// operation[1:0], char_code[9:2], bg_nibble[13:10], fg_nibble[17:14],
	// cell_index[28:18], zeros above
	input  wire logic [TDATA_W-1:0] s_tdata,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// cursor_location[10:0], cell_data[26:11], zeros above
	output logic      [TDATA_W-1:0] m_tdata
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int CNT_W      = $clog2(CELL_COUNT + 1);
	localparam int PH_W       = $clog2(TAB_WIDTH);

	// Input fields.
	op_t               in_op;
	logic [CHAR_W-1:0] in_char;
	logic [NIB_W-1:0]  in_back;
	logic [NIB_W-1:0]  in_fore;
	logic [IDX_W-1:0]  in_idx;

	assign in_op   = op_t'(s_tdata[1:0]);
	assign in_char = s_tdata[9:2];
	assign in_back = s_tdata[13:10];
	assign in_fore = s_tdata[17:14];
	assign in_idx  = s_tdata[28:18];

	state_t state_q, state_d;

	// Cursor. The row base holds row*COLUMNS so no multiply is needed, and the
	// tab phase holds column modulo TAB_WIDTH.
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] base_q;
	logic [PH_W-1:0]   phase_q;

	// Sweep pointer for fill and scroll, and the delayed write of a copy.
	logic [CNT_W-1:0]  ptr_q;
	logic [ADDR_W-1:0] wr_ptr_q;
	logic              wr_pend_q;

	logic [CELL_W-1:0] res_data_q;
	logic              out_valid_q;
	logic [TDATA_W-1:0] out_data_q;

	// Screen memory port.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Put character decode: next column and tab phase, and whether the row
	// advances or the cell under the cursor is written.
	logic [7:0]      col_ext;
	logic [7:0]      col_nx;
	logic [PH_W-1:0] ph_nx;
	logic            row_adv;
	logic            put_wr;
	logic            scroll_nx;

	always_comb begin
		col_ext = 8'(col_q);
		col_nx  = col_ext;
		ph_nx   = phase_q;
		row_adv = 1'b0;
		put_wr  = 1'b0;
		case (in_char)
			CH_BACKSPACE: begin
				if (col_q != '0) begin
					col_nx = col_ext - 8'd1;
					ph_nx  = (phase_q == '0) ? PH_W'(TAB_WIDTH - 1) : phase_q - PH_W'(1);
				end
			end
			CH_TAB: begin
				col_nx = col_ext + 8'(TAB_WIDTH) - 8'(phase_q);
				ph_nx  = '0;
			end
			CH_CR: begin
				col_nx = '0;
				ph_nx  = '0;
			end
			CH_LF: begin
				col_nx  = '0;
				ph_nx   = '0;
				row_adv = 1'b1;
			end
			default: begin
				if (in_char inside {[CH_SPACE:CH_LAST]}) begin
					put_wr = 1'b1;
					col_nx = col_ext + 8'd1;
					ph_nx  = (phase_q == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_q + PH_W'(1);
				end
			end
		endcase
		// Column overflow wraps to the next line.
		if (col_nx >= 8'(COLUMNS)) begin
			col_nx  = '0;
			ph_nx   = '0;
			row_adv = 1'b1;
		end
		scroll_nx = row_adv && (row_q == ROW_W'(ROWS - 1));
	end

	logic accept;
	logic out_free;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = base_q + ADDR_W'(col_q);
		ram_wdata = {in_back, in_fore, in_char};
		ram_raddr = ADDR_W'(in_idx);
		case (state_q)
			ST_INIT, ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q[ADDR_W-1:0];
				ram_wdata = BLANK_CELL;
				if (ptr_q == CNT_W'(CELL_COUNT - 1)) begin
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (in_op)
						OP_PUT: begin
							ram_we  = put_wr;
							state_d = scroll_nx ? ST_SCROLL : ST_DONE;
						end
						OP_CLEAR: state_d = ST_FILL;
						OP_READ:  state_d = (32'(in_idx) < CELL_COUNT) ? ST_READ : ST_DONE;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_READ: state_d = ST_DONE;
			ST_SCROLL: begin
				// Read one row further down, write the previous read back.
				ram_raddr = ptr_q[ADDR_W-1:0];
				ram_we    = wr_pend_q;
				ram_waddr = wr_ptr_q;
				ram_wdata = ram_rdata;
				if (ptr_q == CNT_W'(CELL_COUNT)) begin
					state_d = ST_FILL;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Cursor and sweep registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			base_q    <= '0;
			phase_q   <= '0;
			ptr_q     <= '0;
			wr_pend_q <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT, ST_FILL: ptr_q <= ptr_q + CNT_W'(1);
				ST_IDLE: begin
					if (accept) begin
						case (in_op)
							OP_PUT: begin
								col_q     <= COL_W'(col_nx);
								phase_q   <= ph_nx;
								ptr_q     <= CNT_W'(COLUMNS);
								wr_pend_q <= 1'b0;
								if (row_adv && !scroll_nx) begin
									row_q  <= row_q + ROW_W'(1);
									base_q <= base_q + ADDR_W'(COLUMNS);
								end
							end
							OP_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								base_q  <= '0;
								phase_q <= '0;
								ptr_q   <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SCROLL: begin
					if (ptr_q == CNT_W'(CELL_COUNT)) begin
						wr_pend_q <= 1'b0;
						ptr_q     <= CNT_W'((ROWS - 1) * COLUMNS);
					end else begin
						wr_pend_q <= 1'b1;
						ptr_q     <= ptr_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCROLL) begin
			wr_ptr_q <= ptr_q[ADDR_W-1:0] - ADDR_W'(COLUMNS);
		end
		if (accept) begin
			res_data_q <= '0;
		end else if (state_q == ST_READ) begin
			res_data_q <= ram_rdata;
		end
	end

	// Output register.
	logic [ADDR_W-1:0] loc;

	assign loc = base_q + ADDR_W'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
			out_data_q  <= TDATA_W'({res_data_q, LOC_W'(loc)});
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

@@ design/tcw_checker.sv @@
`default_nettype none

module tcw_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic [TDATA_W-1:0] s_tdata,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [TDATA_W-1:0] m_tdata
);

	localparam int CELL_COUNT = COLUMNS * ROWS;

	// A result that is not taken stays as it is.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The cursor always lies on the screen.
	a_loc_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CELL_COUNT > 2047) || (32'(m_tdata[10:0]) < CELL_COUNT))
		else $error("cursor location off the screen");

	// Items are worked on one at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is at work");

	// Unused result bits stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[TDATA_W-1:27] == '0)
		else $error("result padding not zero");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire

@@ test/console_check_pkg.sv @@
`timescale 1ns / 100ps

package console_check_pkg;
	import tcw_pkg::*;

	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int TAB_STOP    = 8;
	localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

	// Operation code that the block must treat as a no-op.
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [LOC_W-1:0]  location;
		logic [CELL_W-1:0] contents;
	} console_result_t;

	// Keeps a shadow copy of the screen and cursor, and the results still owed.
	class console_scoreboard;
		logic [CELL_W-1:0] screen [CELL_COUNT];
		int column;
		int row;
		int errors;
		int results_seen;
		console_result_t awaited [$];

		function new();
			errors = 0;
			results_seen = 0;
			blank_screen();
		endfunction

		function void blank_screen();
			foreach (screen[i])
				screen[i] = BLANK_CELL;
			column = 0;
			row = 0;
		endfunction

		function int cursor();
			return row * SCREEN_COLS + column;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report(input string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		function void note_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
				input logic [NIB_W-1:0] back, input logic [NIB_W-1:0] fore,
				input logic [IDX_W-1:0] idx);
			console_result_t res;
			int i;
			res.contents = '0;
			case (op)
				OP_PUT: begin
					if (ch == CH_BACKSPACE) begin
						if (column > 0)
							column--;
					end else if (ch == CH_TAB) begin
						column = (column + TAB_STOP) - ((column + TAB_STOP) % TAB_STOP);
					end else if (ch == CH_CR) begin
						column = 0;
					end else if (ch == CH_LF) begin
						column = 0;
						row++;
					end else if (ch >= CH_SPACE && ch <= CH_LAST) begin
						screen[row * SCREEN_COLS + column] = {back, fore, ch};
						column++;
					end
					if (column >= SCREEN_COLS) begin
						column = 0;
						row++;
					end
					// Moving off the bottom scrolls everything up one line.
					if (row >= SCREEN_ROWS) begin
						for (i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
							screen[i] = screen[i + SCREEN_COLS];
						for (i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < CELL_COUNT; i++)
							screen[i] = BLANK_CELL;
						row = SCREEN_ROWS - 1;
					end
				end
				OP_CLEAR: blank_screen();
				OP_READ: begin
					if (idx < CELL_COUNT)
						res.contents = screen[idx];
				end
				default: ;
			endcase
			res.location = LOC_W'(cursor());
			awaited.push_back(res);
		endfunction

		task check_result(input logic [TDATA_W-1:0] word);
			console_result_t want;
			logic [LOC_W-1:0] location;
			logic [CELL_W-1:0] contents;
			location = word[LOC_W-1:0];
			contents = word[LOC_W +: CELL_W];
			if (awaited.size() == 0) begin
				report($sformatf("result item with nothing expected, tdata %h", word));
			end else begin
				want = awaited.pop_front();
				if (location !== want.location)
					report($sformatf("result %0d: cursor_location %0d, expected %0d",
						results_seen, location, want.location));
				if (contents !== want.contents)
					report($sformatf("result %0d: cell_data %h, expected %h",
						results_seen, contents, want.contents));
			end
			results_seen++;
		endtask
	endclass

endpackage

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import tcw_pkg::*;
	import console_check_pkg::*;

	// Scrolls and clears sweep the whole screen, so the watchdog allows every
	// item to be that slow plus the longest gaps and stalls, with margin.
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int RANDOM_ITEMS = 900;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;

	// When set, the sender offers items back to back with no gaps.
	bit sender_steady = 1'b0;

	console_scoreboard console_sb = new();

	text_console_writer #(
		.COLUMNS  (SCREEN_COLS),
		.ROWS     (SCREEN_ROWS),
		.TAB_WIDTH(TAB_STOP)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #1 clk = ~clk;

	// Hang guard: a correct run finishes far below this.
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	// Every result item is compared at the rising edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			console_sb.check_result(m_tdata);
	end

	// Receiver back-pressure: mostly short stalls, now and then a long one,
	// and stretches where it is always ready.
	initial begin : result_sink
		int unsigned hold;
		bit steady;
		hold = 0;
		steady = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 299) == 0)
				steady = !steady;
			if (hold > 0) begin
				m_tready = 1'b0;
				hold--;
			end else begin
				m_tready = 1'b1;
				if (!steady && $urandom_range(0, 99) < 30)
					hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
						: $urandom_range(10, 60);
			end
		end
	end

	// Offers one item after a random gap and holds it until the block takes it.
	// tvalid is left high so that the next item can follow without a bubble.
	task send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
			input logic [NIB_W-1:0] back, input logic [NIB_W-1:0] fore,
			input logic [IDX_W-1:0] idx);
		int gap;
		int pick;
		gap = 0;
		if (!sender_steady) begin
			pick = $urandom_range(0, 99);
			if (pick >= 92)
				gap = $urandom_range(8, 40);
			else if (pick >= 60)
				gap = $urandom_range(1, 3);
		end
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {3'b000, idx, fore, back, ch, op};
		do
			@(posedge clk);
		while (!s_tready);
		console_sb.note_item(op, ch, back, fore, idx);
	endtask

	// Stops offering items until every outstanding result has come back.
	task wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (console_sb.pending() > 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int n;
		int r;
		int lf_rate;
		int loc;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0] idx;

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed part. The block runs a clearing pass after reset, so the first
		// item simply waits for tready. Reads cover both ends of the screen and
		// addresses past it, which must read as zero.
		send_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd0);
		send_item(OP_READ, 8'hFF, 4'hF, 4'hF, 11'd1999);
		send_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd2000);
		send_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd2047);
		// Lowest and highest printable codes with extreme attributes.
		send_item(OP_PUT, CH_SPACE, 4'h0, 4'h0, 11'd2047);
		send_item(OP_PUT, CH_LAST, 4'hF, 4'hF, 11'd0);
		send_item(OP_PUT, 8'h41, 4'hF, 4'h0, 11'd0);
		// High codes are ignored like negative chars; other control codes do nothing.
		send_item(OP_PUT, 8'h80, 4'h5, 4'hA, 11'd0);
		send_item(OP_PUT, 8'hFF, 4'hA, 4'h5, 11'd0);
		send_item(OP_PUT, 8'h00, 4'h0, 4'h0, 11'd0);
		send_item(OP_PUT, 8'h1F, 4'h0, 4'h0, 11'd0);
		// Backspace from column 3, tab to column 8, return, backspace at column 0.
		send_item(OP_PUT, CH_BACKSPACE, 4'h0, 4'h0, 11'd0);
		send_item(OP_PUT, CH_TAB, 4'h0, 4'h0, 11'd0);
		send_item(OP_PUT, CH_CR, 4'h0, 4'h0, 11'd0);
		send_item(OP_PUT, CH_BACKSPACE, 4'h0, 4'h0, 11'd0);
		send_item(OP_PUT, CH_LF, 4'h0, 4'h0, 11'd0);
		send_item(OP_SPARE, 8'h41, 4'hF, 4'hF, 11'd1);
		send_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd0);
		send_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd1);
		send_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd2);
		send_item(OP_CLEAR, 8'hFF, 4'hF, 4'hF, 11'd2047);
		send_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd2);
		send_item(OP_PUT, CH_TAB, 4'h0, 4'h0, 11'd0);
		send_item(OP_PUT, 8'h5A, 4'h3, 4'hC, 11'd1024);
		wait_drained();

		// Random part: text with line breaks, tabs and edits, reads that mostly
		// look back at what was just written, and rare clears. The line-feed rate
		// switches between busy and sparse so that both scrolling and column wrap
		// happen often.
		lf_rate = 150;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				lf_rate = ($urandom_range(0, 1) != 0) ? 150 : 5;
			if (n % 120 == 0)
				sender_steady = ($urandom_range(0, 3) == 0);
			// Pressure point: let the block go completely idle mid-run.
			if (n == RANDOM_ITEMS / 2)
				wait_drained();
			idx = IDX_W'($urandom());
			if ($urandom_range(0, 999) < lf_rate) begin
				send_item(OP_PUT, CH_LF, NIB_W'($urandom()), NIB_W'($urandom()), idx);
			end else begin
				r = $urandom_range(0, 999);
				if (r < 700) begin
					ch = CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
					send_item(OP_PUT, ch, NIB_W'($urandom()), NIB_W'($urandom()), idx);
				end else if (r < 760) begin
					send_item(OP_PUT, CH_TAB, NIB_W'($urandom()), NIB_W'($urandom()), idx);
				end else if (r < 790) begin
					send_item(OP_PUT, CH_CR, NIB_W'($urandom()), NIB_W'($urandom()), idx);
				end else if (r < 830) begin
					send_item(OP_PUT, CH_BACKSPACE, NIB_W'($urandom()), NIB_W'($urandom()),
						idx);
				end else if (r < 860) begin
					ch = CHAR_W'($urandom_range(0, CH_SPACE - 1));
					send_item(OP_PUT, ch, NIB_W'($urandom()), NIB_W'($urandom()), idx);
				end else if (r < 890) begin
					ch = CHAR_W'($urandom_range(8'h80, 8'hFF));
					send_item(OP_PUT, ch, NIB_W'($urandom()), NIB_W'($urandom()), idx);
				end else if (r < 988) begin
					// A third of reads go anywhere, the rest land just behind the cursor.
					if ($urandom_range(0, 2) != 0) begin
						loc = console_sb.cursor();
						idx = IDX_W'(loc - int'($urandom_range(0, (loc < 200) ? loc : 200)));
					end
					send_item(OP_READ, CHAR_W'($urandom()), NIB_W'($urandom()),
						NIB_W'($urandom()), idx);
				end else if (r < 997) begin
					send_item(OP_SPARE, CHAR_W'($urandom()), NIB_W'($urandom()),
						NIB_W'($urandom()), idx);
				end else begin
					send_item(OP_CLEAR, CHAR_W'($urandom()), NIB_W'($urandom()),
						NIB_W'($urandom()), idx);
				end
			end
		end
		wait_drained();

		// Nothing is owed now; give the block a few cycles to show any stray result.
		repeat (16) @(posedge clk);
		if (console_sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ text_console_writer.f @@
design/tcw_pkg.sv
design/tcw_ram.sv
design/text_console_writer.sv
design/tcw_checker.sv
test/console_check_pkg.sv
test/tb.sv
